// ===== hdl/set_assoc_cache_tag_controller_top_assert.svh =====
// Assertion macros for the cache tag controller.
// Included by set_assoc_cache_tag_controller_top; no other dependencies.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SACT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sact assertion failed");
`define SACT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sact assertion failed");
`else
`define SACT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SACT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/sact_pkg.sv =====
// Package for the cache tag controller: geometry constants, state and
// configuration index types. No dependencies.
package sact_pkg;
    localparam int SETS    = 256;
    localparam int WAYS    = 8;
    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);
    localparam int LINES   = SETS * WAYS;
    localparam int LINE_W  = SET_W + WAY_W;
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CYC_W   = 20;
    localparam int BLK_W   = 18;
    localparam int COST_W  = 10;
    localparam int OB_MAX  = 10;
    localparam int ROW_W   = 2 * WAYS;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef enum logic [2:0] {
        CFG_OFFSET_BITS,
        CFG_INDEX_BITS,
        CFG_WAYS_IN_USE,
        CFG_WRITE_ALLOC,
        CFG_WRITE_BACK,
        CFG_LRU_MODE,
        CFG_HIT_COST,
        CFG_MEM_COST
    } t_cfg_idx;
endpackage

// ===== hdl/set_assoc_cache_tag_controller_top.sv =====
// Set-associative cache tag and replacement controller, top level.
// Depends on sact_pkg and set_assoc_cache_tag_controller_top_assert.svh.
//
// After reset the block clears the valid/dirty array, one set per cycle, with
// ready low. An access is then taken in the idle state, after which one
// compare unit walks the ways of the set, each way in turn through a
// registered memory read, then tag compare and age compare; the walk ends
// at the first hitting way or at the last way in use. An update state
// writes the arrays and loads the output register. A new access is taken
// only when the output register is empty.
module set_assoc_cache_tag_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic        o_dirty_writeback,
    output logic [19:0] o_cycles,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    `include "set_assoc_cache_tag_controller_top_assert.svh"

    localparam int SET_W   = sact_pkg::SET_W;
    localparam int WAY_W   = sact_pkg::WAY_W;
    localparam int LINE_W  = sact_pkg::LINE_W;
    localparam int TAG_W   = sact_pkg::TAG_W;
    localparam int STAMP_W = sact_pkg::STAMP_W;
    localparam int CYC_W   = sact_pkg::CYC_W;
    localparam int BLK_W   = sact_pkg::BLK_W;
    localparam int COST_W  = sact_pkg::COST_W;
    localparam int WAYS    = sact_pkg::WAYS;
    localparam int ROW_W   = sact_pkg::ROW_W;

    sact_pkg::t_state r_state, n_state;

    logic [3:0]        r_cfg_ob, r_cfg_ib, r_cfg_ways;
    logic              r_cfg_wa, r_cfg_wb, r_cfg_lru;
    logic [COST_W-1:0] r_cfg_hit_cost, r_cfg_mem_cost;

    logic [STAMP_W-1:0] r_clock;
    logic               r_store;
    logic [TAG_W-1:0]   r_tag;
    logic [SET_W-1:0]   r_set;
    logic [WAY_W-1:0]   r_way, r_nw_m1;
    logic [BLK_W-1:0]   r_blk;
    logic               r_hit_f, r_free_f;
    logic [WAY_W-1:0]   r_hit_way, r_free_way, r_vic_way;
    logic [STAMP_W-1:0] r_best;
    logic [ROW_W-1:0]   r_row;
    logic [SET_W-1:0]   r_clr_cnt;

    logic               r_out_valid, r_out_hit, r_out_wb;
    logic [CYC_W-1:0]   r_out_cycles;

    logic [TAG_W-1:0]   m_tag  [sact_pkg::LINES];
    logic [STAMP_W-1:0] m_fill [sact_pkg::LINES];
    logic [STAMP_W-1:0] m_acc  [sact_pkg::LINES];
    logic [ROW_W-1:0]   m_row  [sact_pkg::SETS];
    logic [TAG_W-1:0]   r_tag_q;
    logic [STAMP_W-1:0] r_fill_q, r_acc_q;
    logic [ROW_W-1:0]   r_row_q;

    logic               w_accept;
    logic [3:0]         w_ob, w_ib;
    logic [3:0]         w_nw;
    logic [SET_W:0]     w_set_mask;
    logic [31:0]        w_shift_addr;
    logic [4:0]         w_tag_sh;
    logic [BLK_W-1:0]   w_blk;

    logic               w_rd_en, w_tag_we, w_acc_we, w_row_we, w_upd;
    logic [LINE_W-1:0]  w_rd_line, w_wr_line;
    logic [SET_W-1:0]   w_row_addr;
    logic [ROW_W-1:0]   w_row_wdata;

    logic               w_v, w_hit_now;
    logic [STAMP_W-1:0] w_age;

    logic               w_alloc, w_wb;
    logic [WAY_W-1:0]   w_alloc_way, w_wr_way;
    logic [ROW_W-1:0]   w_new_row;
    logic [CYC_W-1:0]   w_sto_cost, w_cycles;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_state == sact_pkg::ST_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_valid           = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_dirty_writeback = r_out_wb;
    assign o_cycles          = r_out_cycles;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ob       <= 4'd4;
            r_cfg_ib       <= 4'd8;
            r_cfg_ways     <= 4'd8;
            r_cfg_wa       <= 1'b1;
            r_cfg_wb       <= 1'b1;
            r_cfg_lru      <= 1'b1;
            r_cfg_hit_cost <= 10'd1;
            r_cfg_mem_cost <= 10'd100;
        end else if (i_cfg_valid) begin
            unique case (sact_pkg::t_cfg_idx'(i_cfg_index))
                sact_pkg::CFG_OFFSET_BITS: r_cfg_ob       <= i_cfg_data[3:0];
                sact_pkg::CFG_INDEX_BITS:  r_cfg_ib       <= i_cfg_data[3:0];
                sact_pkg::CFG_WAYS_IN_USE: r_cfg_ways     <= i_cfg_data[3:0];
                sact_pkg::CFG_WRITE_ALLOC: r_cfg_wa       <= i_cfg_data[0];
                sact_pkg::CFG_WRITE_BACK:  r_cfg_wb       <= i_cfg_data[0];
                sact_pkg::CFG_LRU_MODE:    r_cfg_lru      <= i_cfg_data[0];
                sact_pkg::CFG_HIT_COST:    r_cfg_hit_cost <= i_cfg_data;
                sact_pkg::CFG_MEM_COST:    r_cfg_mem_cost <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ob = (r_cfg_ob > 4'(sact_pkg::OB_MAX)) ? 4'(sact_pkg::OB_MAX) : r_cfg_ob;
        w_ib = (r_cfg_ib > 4'(SET_W)) ? 4'(SET_W) : r_cfg_ib;
        if (r_cfg_ways == 4'd0) begin
            w_nw = 4'd1;
        end else if (r_cfg_ways > 4'(WAYS)) begin
            w_nw = 4'(WAYS);
        end else begin
            w_nw = r_cfg_ways;
        end
        w_set_mask   = (SET_W+1)'((SET_W+1)'(1) << w_ib) - (SET_W+1)'(1);
        w_shift_addr = i_address >> w_ob;
        w_tag_sh     = 5'(w_ob) + 5'(w_ib);
        w_blk        = (w_ob < 4'd2) ? '0 : (BLK_W'(r_cfg_mem_cost) << (w_ob - 4'd2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sact_pkg::ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sact_pkg::ST_CLR: begin
                if (r_clr_cnt == SET_W'(sact_pkg::SETS - 1)) n_state = sact_pkg::ST_IDLE;
            end
            sact_pkg::ST_IDLE: begin
                if (w_accept) n_state = sact_pkg::ST_RD;
            end
            sact_pkg::ST_RD: n_state = sact_pkg::ST_CMP;
            sact_pkg::ST_CMP: begin
                if (w_hit_now || r_way == r_nw_m1) begin
                    n_state = sact_pkg::ST_UPD;
                end else begin
                    n_state = sact_pkg::ST_RD;
                end
            end
            sact_pkg::ST_UPD: n_state = sact_pkg::ST_IDLE;
            default: n_state = sact_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en  = 1'b0;
        w_upd    = 1'b0;
        w_row_we = 1'b0;
        unique case (r_state)
            sact_pkg::ST_CLR:  w_row_we = 1'b1;
            sact_pkg::ST_IDLE: ;
            sact_pkg::ST_RD:   w_rd_en  = 1'b1;
            sact_pkg::ST_CMP:  ;
            sact_pkg::ST_UPD: begin
                w_upd    = 1'b1;
                w_row_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_v       = r_row_q[r_way];
        w_hit_now = w_v && (r_tag_q == r_tag);
        w_age     = r_clock - (r_cfg_lru ? r_acc_q : r_fill_q);
    end

    always_comb begin
        w_alloc     = !r_hit_f && (!r_store || r_cfg_wa);
        w_alloc_way = r_free_f ? r_free_way : r_vic_way;
        w_wb        = !r_free_f && r_row[WAYS + 32'(r_vic_way)] && r_cfg_wb;
        w_wr_way    = r_hit_f ? r_hit_way : w_alloc_way;
        w_new_row   = r_row;
        if (r_hit_f) begin
            if (r_store && r_cfg_wb) w_new_row[WAYS + 32'(r_hit_way)] = 1'b1;
        end else if (w_alloc) begin
            w_new_row[w_alloc_way]               = 1'b1;
            w_new_row[WAYS + 32'(w_alloc_way)]   = r_store && r_cfg_wb;
        end
        w_sto_cost = (r_store && !r_cfg_wb) ? CYC_W'(r_cfg_mem_cost) : '0;
        if (r_hit_f) begin
            w_cycles = CYC_W'(r_cfg_hit_cost) + w_sto_cost;
        end else if (!w_alloc) begin
            w_cycles = CYC_W'(r_cfg_mem_cost);
        end else begin
            w_cycles = (w_wb ? CYC_W'(r_blk) : '0) + CYC_W'(r_blk)
                     + CYC_W'(r_cfg_hit_cost) + w_sto_cost;
        end
        w_rd_line   = {r_set, r_way};
        w_wr_line   = {r_set, w_wr_way};
        w_tag_we    = w_upd && !r_hit_f && w_alloc;
        w_acc_we    = w_upd && (r_hit_f || w_alloc);
        w_row_addr  = (r_state == sact_pkg::ST_CLR) ? r_clr_cnt : r_set;
        w_row_wdata = (r_state == sact_pkg::ST_CLR) ? '0 : w_new_row;
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_tag_q  <= m_tag[w_rd_line];
            r_fill_q <= m_fill[w_rd_line];
            r_acc_q  <= m_acc[w_rd_line];
            r_row_q  <= m_row[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            m_tag[w_wr_line]  <= r_tag;
            m_fill[w_wr_line] <= r_clock;
        end
        if (w_acc_we) begin
            m_acc[w_wr_line] <= r_clock;
        end
        if (w_row_we) begin
            m_row[w_row_addr] <= w_row_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == sact_pkg::ST_CLR) r_clr_cnt <= r_clr_cnt + SET_W'(1);
            if (w_accept) r_clock <= r_clock + STAMP_W'(1);
            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store  <= i_req_type;
            r_set    <= SET_W'(w_shift_addr & 32'(w_set_mask));
            r_tag    <= i_address >> w_tag_sh;
            r_way    <= '0;
            r_nw_m1  <= WAY_W'(w_nw - 4'd1);
            r_blk    <= w_blk;
            r_hit_f  <= 1'b0;
            r_free_f <= 1'b0;
        end else if (r_state == sact_pkg::ST_CMP) begin
            r_row <= r_row_q;
            if (w_hit_now) begin
                r_hit_f   <= 1'b1;
                r_hit_way <= r_way;
            end
            if (!w_v && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_way <= r_way;
            end
            if (r_way == '0 || w_age > r_best) begin
                r_best    <= w_age;
                r_vic_way <= r_way;
            end
            r_way <= r_way + WAY_W'(1);
        end
        if (w_upd) begin
            r_out_hit    <= r_hit_f;
            r_out_wb     <= w_alloc && w_wb;
            r_out_cycles <= w_cycles;
        end
    end

    `SACT_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, w_accept, r_state == sact_pkg::ST_RD)
    `SACT_ASSERT_IMPLY(a_rose_after_upd, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == sact_pkg::ST_UPD))
    `SACT_ASSERT_IMPLY(a_hit_no_wb, i_clk, i_rst_n, r_out_valid, !(r_out_hit && r_out_wb))
    `SACT_ASSERT_IMPLY(a_clr_blocks, i_clk, i_rst_n, r_state == sact_pkg::ST_CLR, !o_ready)
endmodule
